/* rtl/skwt_pkg.sv */
// shared types and constants for the skinning weight top-4 accumulator
package skwt_pkg;

  localparam int SLOTS     = 4;
  localparam int VERT_W    = 12;
  localparam int VCOUNT_W  = 13;
  localparam int WEIGHT_W  = 17;
  localparam int BONE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int SUM_W     = 19;
  localparam int FRAC_W    = 16;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS     = FRAC_W / BITS_PER_STEP;
  localparam int SLOT_IDX_W = 2;
  localparam int STEP_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;
  localparam logic [WEIGHT_W-1:0] MIN_WEIGHT_RESET = 17'd66;
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT   = 1'd1;

  // item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FILLED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BELOW_THRESH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_VERTEX   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ         = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_DEFAULT = 3'd6;

  // one vertex row of the influence store
  typedef struct packed {
    logic [SLOTS-1:0][WEIGHT_W-1:0] w;
    logic [SLOTS-1:0][BONE_W-1:0]   b;
  } row_t;

endpackage

/* rtl/skin_weight_top4_accumulator_core.sv */
// skinning weight top-4 accumulator: influence store, sequencer and shared divider
//
// An item is taken when start is high and busy is low; its single result appears for one
// cycle with done high and cannot be held off. A rejected item (bad vertex, or an add whose
// weight is below min_weight) gives its result in the cycle right after it is taken. Other
// adds read the vertex row from the store, are judged in S_EVAL and give their result from
// there. A read normalizes the four weights with one shared restoring divider that retires 4
// quotient bits a cycle, one slot after another; a read whose weights sum to zero gives its
// default result from S_EVAL. After reset the store is swept to zero one vertex row a cycle
// with busy high; configuration writes are taken during the sweep.
module skin_weight_top4_accumulator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [skwt_pkg::VERT_W-1:0]    vertex_id,
  input  logic [skwt_pkg::BONE_W-1:0]    bone_id,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  weight,
  input  logic                           wr_en,
  input  logic [skwt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  wr_data,
  output logic                           done,
  output logic [skwt_pkg::STATUS_W-1:0]  status,
  output logic [skwt_pkg::WEIGHT_W-1:0]  weight_0,
  output logic [skwt_pkg::WEIGHT_W-1:0]  weight_1,
  output logic [skwt_pkg::WEIGHT_W-1:0]  weight_2,
  output logic [skwt_pkg::WEIGHT_W-1:0]  weight_3,
  output logic [skwt_pkg::BONE_W-1:0]    bone_0,
  output logic [skwt_pkg::BONE_W-1:0]    bone_1,
  output logic [skwt_pkg::BONE_W-1:0]    bone_2,
  output logic [skwt_pkg::BONE_W-1:0]    bone_3
);
  import skwt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DSTEP = 3'd4;

  logic [2:0] state;

  // configuration
  logic [VCOUNT_W-1:0] vertex_count;
  logic [WEIGHT_W-1:0] min_weight;

  // latched item
  logic                kind_r;
  logic [VERT_W-1:0]   vid_r;
  logic [BONE_W-1:0]   bone_r;
  logic [WEIGHT_W-1:0] weight_r;

  // store
  row_t                mem [0:(1 << VERT_W)-1];
  row_t                mem_rdata;
  logic                mem_we;
  logic [VERT_W-1:0]   mem_waddr;
  row_t                mem_wdata;
  logic [VERT_W-1:0]   clr_addr;

  // divider and read datapath
  logic [SLOTS-1:0][WEIGHT_W-1:0] row_w;
  logic [SLOTS-1:0][BONE_W-1:0]   row_b;
  logic [SUM_W-1:0]               dsum;
  logic [SUM_W-1:0]               rem;
  logic [SUM_W-1:0]               rem_next;
  logic [FRAC_W-1:0]              quo;
  logic [FRAC_W-1:0]              quo_next;
  logic                           qhi;
  logic [SLOT_IDX_W-1:0]          slot;
  logic [STEP_W-1:0]              step;

  // output registers
  logic [SLOTS-1:0][WEIGHT_W-1:0] out_w;
  logic [SLOTS-1:0][BONE_W-1:0]   out_b;

  // eval combinational
  logic [SUM_W-1:0]      row_sum;
  logic                  any_empty;
  logic [SLOT_IDX_W-1:0] first_empty;
  logic [SLOT_IDX_W-1:0] min_idx;
  logic                  accept;
  logic                  bad_vertex;

  assign accept     = start && (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign bad_vertex = ({1'b0, vertex_id} >= vertex_count);

  assign weight_0 = out_w[0];
  assign weight_1 = out_w[1];
  assign weight_2 = out_w[2];
  assign weight_3 = out_w[3];
  assign bone_0   = out_b[0];
  assign bone_1   = out_b[1];
  assign bone_2   = out_b[2];
  assign bone_3   = out_b[3];

  always_comb begin
    row_sum = '0;
    any_empty = 1'b0;
    first_empty = '0;
    min_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      row_sum = row_sum + SUM_W'(mem_rdata.w[s]);
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (mem_rdata.w[s] == '0) begin
        any_empty = 1'b1;
        first_empty = SLOT_IDX_W'(s);
      end
    end
    // lowest index wins on ties
    for (int s = 1; s < SLOTS; s++) begin
      if (mem_rdata.w[s] < mem_rdata.w[min_idx]) begin
        min_idx = SLOT_IDX_W'(s);
      end
    end
  end

  // shared divider step: BITS_PER_STEP restoring bits per cycle
  always_comb begin
    logic [SUM_W:0] trial;
    trial = '0;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {rem_next, 1'b0};
      if (trial >= {1'b0, dsum}) begin
        rem_next = SUM_W'(trial - {1'b0, dsum});
        quo_next = {quo_next[FRAC_W-2:0], 1'b1};
      end else begin
        rem_next = trial[SUM_W-1:0];
        quo_next = {quo_next[FRAC_W-2:0], 1'b0};
      end
    end
  end

  // store write port
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = vid_r;
    mem_wdata = mem_rdata;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_EVAL: begin
        if (kind_r == KIND_READ) begin
          mem_we = 1'b1;
          mem_wdata = '0;
        end else if (any_empty) begin
          mem_we = 1'b1;
          mem_wdata.w[first_empty] = weight_r;
          mem_wdata.b[first_empty] = bone_r;
        end else if (weight_r > mem_rdata.w[min_idx]) begin
          mem_we = 1'b1;
          mem_wdata.w[min_idx] = weight_r;
          mem_wdata.b[min_idx] = bone_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[vertex_id];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
      min_weight <= MIN_WEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_VERTEX_COUNT: vertex_count <= wr_data[VCOUNT_W-1:0];
        REG_MIN_WEIGHT:   min_weight <= wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          done <= 1'b0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_r <= kind;
            vid_r <= vertex_id;
            bone_r <= bone_id;
            weight_r <= weight;
            if (bad_vertex) begin
              done <= 1'b1;
              status <= ST_BAD_VERTEX;
              out_w <= '0;
              out_b <= '0;
            end else if (kind == KIND_ADD && weight < min_weight) begin
              done <= 1'b1;
              status <= ST_BELOW_THRESH;
              out_w <= '0;
              out_b <= '0;
            end else begin
              done <= 1'b0;
              state <= S_EVAL;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_EVAL: begin
          if (kind_r == KIND_ADD) begin
            done <= 1'b1;
            out_w <= '0;
            out_b <= '0;
            if (any_empty) begin
              status <= ST_FILLED;
            end else if (weight_r > mem_rdata.w[min_idx]) begin
              status <= ST_REPLACED;
            end else begin
              status <= ST_DROPPED;
            end
            state <= S_IDLE;
          end else if (row_sum == '0) begin
            done <= 1'b1;
            status <= ST_READ_DEFAULT;
            out_w <= {{((SLOTS - 1) * WEIGHT_W){1'b0}}, ONE_Q16};
            out_b <= {mem_rdata.b[SLOTS-1:1], {BONE_W{1'b0}}};
            state <= S_IDLE;
          end else begin
            done <= 1'b0;
            row_w <= mem_rdata.w;
            row_b <= mem_rdata.b;
            dsum <= row_sum;
            slot <= '0;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          done <= 1'b0;
          // a slot weight never exceeds the sum, so the integer part is 0 or 1
          qhi <= ({2'b0, row_w[slot]} >= dsum);
          rem <= ({2'b0, row_w[slot]} >= dsum) ? '0 : {2'b0, row_w[slot]};
          quo <= '0;
          step <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          rem <= rem_next;
          quo <= quo_next;
          step <= step + 1'b1;
          if (step == STEP_W'(STEPS - 1)) begin
            out_w[slot] <= {qhi, quo_next};
            if (slot == SLOT_IDX_W'(SLOTS - 1)) begin
              done <= 1'b1;
              status <= ST_READ;
              out_b <= row_b;
              state <= S_IDLE;
            end else begin
              done <= 1'b0;
              slot <= slot + 1'b1;
              state <= S_DINIT;
            end
          end else begin
            done <= 1'b0;
          end
        end
        default: begin
          done <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result word during store sweep");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted word neither finished nor in progress");

  a_add_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_READ && status != ST_READ_DEFAULT) |->
      (out_w == '0 && out_b == '0))
    else $error("add result carries nonzero fields");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTEP) |-> (rem < dsum))
    else $error("divider remainder out of range");

  a_read_done_idle: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_READ) |-> (state == S_IDLE))
    else $error("read result while sequencer still active");

endmodule

/* tb/skin_blend_checker.sv */
// result checker for the skinning weight accumulator: predicts every result word and compares
`timescale 1ns / 100ps
module skin_blend_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           kind,
  input  logic [skwt_pkg::VERT_W-1:0]    vertex_id,
  input  logic [skwt_pkg::BONE_W-1:0]    bone_id,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  weight,
  input  logic                           wr_en,
  input  logic [skwt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  wr_data,
  input  logic                           done,
  input  logic [skwt_pkg::STATUS_W-1:0]  status,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  weight_0,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  weight_1,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  weight_2,
  input  logic [skwt_pkg::WEIGHT_W-1:0]  weight_3,
  input  logic [skwt_pkg::BONE_W-1:0]    bone_0,
  input  logic [skwt_pkg::BONE_W-1:0]    bone_1,
  input  logic [skwt_pkg::BONE_W-1:0]    bone_2,
  input  logic [skwt_pkg::BONE_W-1:0]    bone_3,
  output int                             fail_count,
  output int                             n_open
);
  import skwt_pkg::*;

  localparam int VERTICES = 1 << VERT_W;

  typedef struct packed {
    logic [STATUS_W-1:0]            st;
    logic [SLOTS-1:0][WEIGHT_W-1:0] w;
    logic [SLOTS-1:0][BONE_W-1:0]   b;
  } blend_t;

  logic [WEIGHT_W-1:0] slot_w [VERTICES][SLOTS];
  logic [BONE_W-1:0]   slot_b [VERTICES][SLOTS];
  logic [VCOUNT_W-1:0] vcount;
  logic [WEIGHT_W-1:0] wmin;
  blend_t              blend_q [$];
  blend_t              got;
  blend_t              want;

  // applies one word to the influence store and returns the result it should give
  function automatic blend_t settle_influence(input logic k, input logic [VERT_W-1:0] vid,
                                              input logic [BONE_W-1:0] bn,
                                              input logic [WEIGHT_W-1:0] w);
    blend_t                        r;
    logic                          placed;
    int                            mi;
    logic [SUM_W-1:0]              total;
    logic [WEIGHT_W+FRAC_W-1:0]    quo;
    r = '0;
    placed = 1'b0;
    mi = 0;
    total = '0;
    if ({1'b0, vid} >= vcount) begin
      r.st = ST_BAD_VERTEX;
      return r;
    end
    if (k == KIND_ADD) begin
      // bone ids are 8 bits wide, so every bone is in range
      if (w < wmin) begin
        r.st = ST_BELOW_THRESH;
        return r;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (!placed && slot_w[vid][s] == '0) begin
          slot_w[vid][s] = w;
          slot_b[vid][s] = bn;
          placed = 1'b1;
        end
      end
      if (placed) begin
        r.st = ST_FILLED;
        return r;
      end
      // smallest slot, lowest index on ties
      for (int s = 1; s < SLOTS; s++)
        if (slot_w[vid][s] < slot_w[vid][mi]) mi = s;
      if (w > slot_w[vid][mi]) begin
        slot_w[vid][mi] = w;
        slot_b[vid][mi] = bn;
        r.st = ST_REPLACED;
      end else begin
        r.st = ST_DROPPED;
      end
      return r;
    end
    for (int s = 0; s < SLOTS; s++) total += slot_w[vid][s];
    if (total == '0) begin
      r.st = ST_READ_DEFAULT;
      r.w[0] = ONE_Q16;
      for (int s = 1; s < SLOTS; s++) r.b[s] = slot_b[vid][s];
    end else begin
      r.st = ST_READ;
      for (int s = 0; s < SLOTS; s++) begin
        quo = {slot_w[vid][s], {FRAC_W{1'b0}}} / total;
        r.w[s] = quo[WEIGHT_W-1:0];
        r.b[s] = slot_b[vid][s];
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      slot_w[vid][s] = '0;
      slot_b[vid][s] = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VERTICES; v++)
        for (int s = 0; s < SLOTS; s++) begin
          slot_w[v][s] = '0;
          slot_b[v][s] = '0;
        end
      vcount = VCOUNT_RESET;
      wmin = MIN_WEIGHT_RESET;
      blend_q.delete();
      fail_count = 0;
      n_open = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_VERTEX_COUNT: vcount = wr_data[VCOUNT_W-1:0];
          REG_MIN_WEIGHT:   wmin = wr_data;
          default:          ;
        endcase
      end
      // retire the result word before taking a new one at the same edge
      if (done) begin
        got.st = status;
        got.w = {weight_3, weight_2, weight_1, weight_0};
        got.b = {bone_3, bone_2, bone_1, bone_0};
        if (blend_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with none expected, st %0d w %h b %h",
                     $time, got.st, got.w, got.b);
        end else begin
          want = blend_q.pop_front();
          n_open--;
          if (got.st !== want.st || got.w !== want.w || got.b !== want.b) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch st exp %0d got %0d, w exp %h got %h, b exp %h got %h",
                       $time, want.st, got.st, want.w, got.w, want.b, got.b);
          end
        end
      end
      if (start && !busy) begin
        blend_q.push_back(settle_influence(kind, vertex_id, bone_id, weight));
        n_open++;
      end
    end
  end

endmodule

/* tb/skin_weight_top4_accumulator_core_tb.sv */
// stimulus, watchdog and verdict for the skinning weight top-4 accumulator
`timescale 1ns / 100ps
module skin_weight_top4_accumulator_core_tb;
  import skwt_pkg::*;

  localparam int SETTLE      = 30;
  localparam int QUIET_LIMIT = 20000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 kind      = KIND_ADD;
  logic [VERT_W-1:0]    vertex_id = '0;
  logic [BONE_W-1:0]    bone_id   = '0;
  logic [WEIGHT_W-1:0]  weight    = '0;
  logic                 wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index  = REG_VERTEX_COUNT;
  logic [WEIGHT_W-1:0]  wr_data   = '0;
  logic                 busy;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [WEIGHT_W-1:0]  weight_0, weight_1, weight_2, weight_3;
  logic [BONE_W-1:0]    bone_0, bone_1, bone_2, bone_3;

  int          fail_count;
  int          n_open;
  int          sent       = 0;
  int          quiet      = 0;
  bit          steady     = 1'b0;
  int unsigned vcount_now = VCOUNT_RESET;
  int unsigned wmin_now   = MIN_WEIGHT_RESET;

  skin_weight_top4_accumulator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .vertex_id(vertex_id), .bone_id(bone_id), .weight(weight),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .status(status),
    .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2), .weight_3(weight_3),
    .bone_0(bone_0), .bone_1(bone_1), .bone_2(bone_2), .bone_3(bone_3)
  );

  skin_blend_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .vertex_id(vertex_id), .bone_id(bone_id), .weight(weight),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .status(status),
    .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2), .weight_3(weight_3),
    .bone_0(bone_0), .bone_1(bone_1), .bone_2(bone_2), .bone_3(bone_3),
    .fail_count(fail_count), .n_open(n_open)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // start is only lowered on a gap, so back-to-back words keep it high
  task automatic send_word(input logic k, input logic [VERT_W-1:0] vid,
                           input logic [BONE_W-1:0] bn, input logic [WEIGHT_W-1:0] w);
    while (!steady && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    vertex_id <= vid;
    bone_id <= bn;
    weight <= w;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic set_regs(input int unsigned vc, input int unsigned mw);
    wr_en <= 1'b1;
    wr_index <= REG_VERTEX_COUNT;
    wr_data <= WEIGHT_W'(vc);
    @(posedge clk);
    wr_index <= REG_MIN_WEIGHT;
    wr_data <= WEIGHT_W'(mw);
    @(posedge clk);
    wr_en <= 1'b0;
    vcount_now = vc;
    wmin_now = mw;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (n_open != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned r;
    int unsigned near;
    r = $urandom_range(99);
    near = wmin_now + $urandom_range(3);
    if (r < 8 && wmin_now > 0) return WEIGHT_W'($urandom_range(wmin_now - 1));
    if (r < 14) return ONE_Q16;
    if (r < 20) return WEIGHT_W'(wmin_now);
    if (r < 25) return WEIGHT_W'($urandom_range(16));
    // clustered weights make ties and equal-to-smallest drops likely
    if (r < 35) return WEIGHT_W'((near > 65536) ? 65536 : near);
    return WEIGHT_W'($urandom_range(65536, wmin_now));
  endfunction

  // mostly fill-then-read sequences on valid vertices, the rest random noise
  task automatic random_run(input int n);
    int                stop;
    int                adds;
    int unsigned       r;
    logic [VERT_W-1:0] vid;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 75) begin
        vid = VERT_W'($urandom_range(vcount_now - 1));
        adds = $urandom_range(7, 1);
        repeat (adds) send_word(KIND_ADD, vid, BONE_W'($urandom), pick_weight());
        if ($urandom_range(9) != 0)
          send_word(KIND_READ, vid, BONE_W'($urandom), WEIGHT_W'($urandom_range(65536)));
      end else if (r < 80 && vcount_now < (1 << VERT_W)) begin
        send_word($urandom_range(1) == 1, VERT_W'(vcount_now), BONE_W'($urandom),
                  pick_weight());
      end else begin
        send_word($urandom_range(1) == 1, VERT_W'($urandom), BONE_W'($urandom),
                  WEIGHT_W'($urandom_range(65536)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // threshold edge, fill, equal-weight drop, replace, read, zero-sum read
    send_word(KIND_ADD, 12'd0, 8'd0, ONE_Q16);
    send_word(KIND_ADD, 12'd0, 8'hFF, 17'd66);
    send_word(KIND_ADD, 12'd0, 8'h55, 17'd65);
    send_word(KIND_ADD, 12'd0, 8'hAA, 17'd1000);
    send_word(KIND_ADD, 12'd0, 8'd3, 17'd500);
    send_word(KIND_ADD, 12'd0, 8'd9, 17'd66);
    send_word(KIND_ADD, 12'd0, 8'd10, 17'd67);
    send_word(KIND_READ, 12'd0, 8'd0, '0);
    send_word(KIND_READ, 12'd0, 8'hFF, ONE_Q16);
    // ties replace the lowest index
    send_word(KIND_ADD, 12'hFFF, 8'd1, 17'd300);
    send_word(KIND_ADD, 12'hFFF, 8'd2, 17'd300);
    send_word(KIND_ADD, 12'hFFF, 8'd3, 17'd300);
    send_word(KIND_ADD, 12'hFFF, 8'd4, 17'd300);
    send_word(KIND_ADD, 12'hFFF, 8'd5, 17'd400);
    send_word(KIND_ADD, 12'hFFF, 8'd6, 17'd300);
    send_word(KIND_READ, 12'hFFF, 8'd0, '0);
    steady = 1'b1;
    random_run(150);
    steady = 1'b0;
    random_run(350);
    drain();

    // single vertex, no threshold: bad vertices and zero weights
    set_regs(1, 0);
    send_word(KIND_ADD, 12'd1, 8'd1, 17'd100);
    send_word(KIND_READ, 12'hFFF, 8'd0, '0);
    send_word(KIND_ADD, 12'd0, 8'd7, '0);
    send_word(KIND_ADD, 12'd0, 8'd9, '0);
    send_word(KIND_READ, 12'd0, 8'd0, '0);
    send_word(KIND_ADD, 12'd0, 8'd2, 17'd5);
    send_word(KIND_ADD, 12'd0, 8'd4, '0);
    send_word(KIND_READ, 12'd0, 8'd0, '0);
    random_run(200);
    drain();

    set_regs(1 << VERT_W, 65536);
    random_run(200);
    drain();

    repeat (3) begin
      set_regs($urandom_range(1 << VERT_W, 1), $urandom_range(3000));
      random_run(280);
      drain();
    end

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/skwt_pkg.sv
rtl/skin_weight_top4_accumulator_core.sv
tb/skin_blend_checker.sv
tb/skin_weight_top4_accumulator_core_tb.sv
